### rtl/nps_pkg.sv
// Package for the nearest point search block: sizes, field layout, codes and types.
// Used by nearest_point_search and its checker; depends on nothing else.
package nps_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int NUM_SETS   = 128;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    localparam int ACTION_W = 2;
    localparam int SET_W    = 7;
    localparam int COORD_W  = 15;
    localparam int IDX_W    = 10;
    localparam int LIMIT_W  = 18;

    localparam int SQ_W   = 2 * COORD_W;
    localparam int DIST_W = SQ_W + 1;
    localparam int BEST_W = 2 * LIMIT_W;

    localparam int SET_LSB = 0;
    localparam int X_LSB   = SET_LSB + SET_W;
    localparam int Y_LSB   = X_LSB + COORD_W;
    localparam int IN_FIELDS_W = Y_LSB + COORD_W;
    localparam int S_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((IDX_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(160000);

    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SET     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 2'd1;

    typedef struct packed {
        logic [SET_W-1:0]   set;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } point_t;

    localparam int POINT_W = $bits(point_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

endpackage

### rtl/nps_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Self-contained; used for the point store of nearest_point_search.
module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/nearest_point_search.sv
// Top level of the nearest point search block: command decode, scan sequencer and distance pipe.
// Depends on nps_pkg and nps_ram.
//
// The block stores up to MAX_POINTS points, each tagged with a set number, in one memory.
// A clear or add word is taken and gives no result. A query word scans every
// stored point through the single read port of the point memory, one point per cycle, so it
// occupies the block until the distance pipe has drained, and longer while an earlier
// result word still waits; input is not taken during the scan. The result word waits in an
// output register, and clears and adds are taken while it waits. Configuration writes are
// taken in any cycle. No clearing pass follows reset.
module nearest_point_search (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [nps_pkg::S_TDATA_W-1:0]   s_tdata,   // point_set, pos_x, pos_y
    input  logic [nps_pkg::ACTION_W-1:0]    s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [nps_pkg::M_TDATA_W-1:0]   m_tdata,   // nearest_index
    output logic [nps_pkg::M_TUSER_W-1:0]   m_tuser,   // found, changed
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import nps_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   scan_reg;
    logic [COORD_W-1:0] qx_reg, qy_reg;
    logic [BEST_W-1:0]  best_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   bidx_reg;
    logic [CNT_W-1:0]   k_reg;

    logic               v1_reg, v2_reg, v3_reg;
    logic               m2_reg, m3_reg;
    logic [COORD_W-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;

    logic [SET_W-1:0]   active_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               prev_found_reg;
    logic [IDX_W-1:0]   prev_idx_reg;
    logic               out_valid_reg, out_found_reg, out_changed_reg;
    logic [IDX_W-1:0]   out_idx_reg;

    logic               in_acc;
    logic [SET_W-1:0]   in_set;
    logic [COORD_W-1:0] in_x, in_y;
    point_t             wr_point, rd_point;
    logic [POINT_W-1:0] rd_word;
    logic               wr_en, rd_en;
    logic               out_free, pipe_empty, finish;
    logic [DIST_W-1:0]  dist_sum;
    logic [COORD_W-1:0] dx, dy;

    assign in_acc = s_tvalid && s_tready;
    assign in_set = s_tdata[SET_LSB +: SET_W];
    assign in_x   = s_tdata[X_LSB +: COORD_W];
    assign in_y   = s_tdata[Y_LSB +: COORD_W];

    assign wr_point = '{set: in_set, y: in_y, x: in_x};
    assign wr_en    = in_acc && (s_tuser == ACT_ADD) && (count_reg < CNT_W'(MAX_POINTS))
                      && (32'(in_set) < NUM_SETS);
    assign rd_en    = (state_reg == ST_SCAN) && (scan_reg != count_reg);
    assign rd_point = rd_word;

    nps_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_point),
        .rd_en   (rd_en),
        .rd_addr (scan_reg[ADDR_W-1:0]),
        .rd_data (rd_word)
    );

    assign dx = (rd_point.x > qx_reg) ? rd_point.x - qx_reg : qx_reg - rd_point.x;
    assign dy = (rd_point.y > qy_reg) ? rd_point.y - qy_reg : qy_reg - rd_point.y;
    assign dist_sum = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    assign out_free   = !out_valid_reg || m_tready;
    assign pipe_empty = !v1_reg && !v2_reg && !v3_reg;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (in_acc && (s_tuser == ACT_QUERY)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_reg == count_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty && out_free) begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            active_reg     <= '0;
            limit_reg      <= LIMIT_RESET;
            prev_found_reg <= 1'b1;
            prev_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_acc && (s_tuser == ACT_CLEAR)) begin
                count_reg <= '0;
            end else if (wr_en) begin
                count_reg <= count_reg + 1'b1;
            end

            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ACTIVE_SET:     active_reg <= cfg_data[SET_W-1:0];
                    CFG_DISTANCE_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (finish) begin
                out_valid_reg  <= 1'b1;
                prev_found_reg <= found_reg;
                prev_idx_reg   <= bidx_reg;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && (s_tuser == ACT_QUERY)) begin
            qx_reg    <= in_x;
            qy_reg    <= in_y;
            best_reg  <= BEST_W'(limit_reg) * BEST_W'(limit_reg);
            found_reg <= 1'b0;
            bidx_reg  <= '0;
            k_reg     <= '0;
            scan_reg  <= '0;
        end else begin
            if (rd_en) begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (v3_reg && m3_reg) begin
                k_reg <= k_reg + 1'b1;
                if (BEST_W'(dist_sum) < best_reg) begin
                    best_reg  <= BEST_W'(dist_sum);
                    found_reg <= 1'b1;
                    bidx_reg  <= IDX_W'(k_reg);
                end
            end
        end

        dx_reg  <= dx;
        dy_reg  <= dy;
        m2_reg  <= (rd_point.set == active_reg);
        sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        m3_reg  <= m2_reg;

        if (finish) begin
            out_found_reg   <= found_reg;
            out_idx_reg     <= bidx_reg;
            out_changed_reg <= (found_reg != prev_found_reg) || (bidx_reg != prev_idx_reg);
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_TDATA_W'(out_idx_reg);
    assign m_tuser   = {out_changed_reg, out_found_reg};
    assign cfg_ready = 1'b1;

endmodule

### rtl/nps_checker.sv
// Port-level checker for nearest_point_search, attached to the top level by a bind statement.
// Depends on nps_pkg.
module nps_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [nps_pkg::ACTION_W-1:0]   s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [nps_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [nps_pkg::M_TUSER_W-1:0]  m_tuser
);

    import nps_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[IDX_W-1:0] == '0)
        else $error("index not zero when nothing found");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == ACT_QUERY) |=> !s_tready)
        else $error("input taken during a query scan");

    a_cmd_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != ACT_QUERY) |=> s_tready)
        else $error("clear or add word stalled the input");

endmodule

bind nearest_point_search nps_checker u_nps_checker (.*);

### bench/tb_nearest_point_search.sv
// Self-checking bench for nearest_point_search: random bursts of clear, add and query words
// against a built-in table model, with register changes between phases. Depends on nps_pkg and nearest_point_search.
module tb_nearest_point_search;
    timeunit 1ns;
    timeprecision 1ps;

    import nps_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int COORD_MAX = (1 << COORD_W) - 1;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SET_W-1:0]    set;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
    } word_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
        logic             changed;
    } nearest_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [ACTION_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    nearest_point_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Point table and registers as the block should hold them.
    logic [COORD_W-1:0] pt_x [MAX_POINTS];
    logic [COORD_W-1:0] pt_y [MAX_POINTS];
    logic [SET_W-1:0]   pt_set [MAX_POINTS];
    int                 stored = 0;
    logic               prev_found = 1'b1;
    logic [IDX_W-1:0]   prev_index = '0;
    logic [SET_W-1:0]   sel_set = '0;
    logic [LIMIT_W-1:0] sel_limit = LIMIT_RESET;

    word_t    pending_words[$];
    nearest_t expected_results[$];
    word_t    cur_word;
    int       burst_left = 0;
    int       gap_left = 0;
    int       mismatches = 0;
    int       idle_cycles = 0;
    logic [9:0] beat = '0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void apply_command(input word_t w);
        nearest_t        r;
        longint unsigned best, d, dx, dy;
        int              k;
        case (w.action)
            ACT_CLEAR: stored = 0;
            ACT_ADD: begin
                if (stored < MAX_POINTS && int'(w.set) < NUM_SETS) begin
                    pt_x[stored] = w.x;
                    pt_y[stored] = w.y;
                    pt_set[stored] = w.set;
                    stored++;
                end
            end
            ACT_QUERY: begin
                best = longint'(sel_limit) * longint'(sel_limit);
                r = '0;
                k = 0;
                for (int i = 0; i < stored; i++) begin
                    if (pt_set[i] == sel_set) begin
                        dx = (w.x > pt_x[i]) ? w.x - pt_x[i] : pt_x[i] - w.x;
                        dy = (w.y > pt_y[i]) ? w.y - pt_y[i] : pt_y[i] - w.y;
                        d = dx * dx + dy * dy;
                        if (d < best) begin
                            best = d;
                            r.found = 1'b1;
                            r.index = k[IDX_W-1:0];
                        end
                        k++;
                    end
                end
                r.changed = (r.found != prev_found) || (r.index != prev_index);
                prev_found = r.found;
                prev_index = r.index;
                expected_results = {expected_results, r};
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_word(input logic [ACTION_W-1:0] action, input int set,
                                       input int x, input int y);
        word_t w;
        w.action = action;
        w.set = SET_W'(set);
        w.x = COORD_W'(x);
        w.y = COORD_W'(y);
        pending_words = {pending_words, w};
    endfunction

    function automatic int jitter_coord(input int c, input int spread);
        int v;
        v = c + int'($urandom_range(0, 2 * spread)) - spread;
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic int pick_center();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return COORD_MAX;
            default: return $urandom_range(0, COORD_MAX);
        endcase
    endfunction

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ACTIVE_SET) begin
            sel_set = value[SET_W-1:0];
        end else if (idx == CFG_DISTANCE_LIMIT) begin
            sel_limit = value[LIMIT_W-1:0];
        end
    endtask

    task automatic note_mismatch(input string what, input nearest_t want, input nearest_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t ns: %s: expected found=%0d index=%0d changed=%0d, got found=%0d index=%0d changed=%0d",
                     $time, what, want.found, want.index, want.changed,
                     got.found, got.index, got.changed);
        end
    endtask

    // Word driver: pulls from the pending queue in bursts with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_command(cur_word);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || pending_words.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    cur_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_word.action;
                    s_tdata <= S_TDATA_W'({cur_word.y, cur_word.x, cur_word.set});
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Result monitor with a receiver stall pattern that steps through four modes on beat[9:8].
    always @(posedge aclk) begin
        nearest_t got;
        nearest_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            beat <= '0;
        end else begin
            beat <= beat + 1'b1;
            if (m_tvalid && m_tready) begin
                got.found = m_tuser[0];
                got.index = m_tdata[IDX_W-1:0];
                got.changed = m_tuser[1];
                if (expected_results.size() == 0) begin
                    note_mismatch("unexpected result word", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) note_mismatch("result mismatch", want, got);
                end
            end
            case (beat[9:8])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= (beat[2:0] != 3'd0);
                2'd2: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= beat[4];
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int                 n_rand;
        int                 phase;
        int                 spread;
        int                 cx;
        int                 cy;
        int                 qx;
        int                 qy;
        bit                 filled;
        logic [SET_W-1:0]   aset;
        logic [LIMIT_W-1:0] lim;
        n_rand = 0;
        phase = 0;
        filled = 1'b0;
        qx = 0;
        qy = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty table, unused code, edge coordinates, ties and clear, at reset settings.
        queue_word(ACT_QUERY, 0, 0, 0);
        queue_word(ACT_QUERY, 0, COORD_MAX, COORD_MAX);
        queue_word(ACT_UNUSED, 127, COORD_MAX, COORD_MAX);
        queue_word(ACT_ADD, 0, 0, 0);
        queue_word(ACT_ADD, 127, COORD_MAX, COORD_MAX);
        queue_word(ACT_ADD, 0, COORD_MAX, COORD_MAX);
        queue_word(ACT_ADD, 0, 200, 100);
        queue_word(ACT_ADD, 0, 0, 100);
        queue_word(ACT_QUERY, 0, 100, 100);
        queue_word(ACT_ADD, 0, 100, 100);
        queue_word(ACT_ADD, 0, 100, 100);
        queue_word(ACT_QUERY, 0, 100, 101);
        queue_word(ACT_QUERY, 0, COORD_MAX, COORD_MAX);
        queue_word(ACT_QUERY, 0, COORD_MAX, COORD_MAX);
        queue_word(ACT_QUERY, 127, 0, 0);
        queue_word(ACT_CLEAR, 127, COORD_MAX, COORD_MAX);
        queue_word(ACT_QUERY, 0, 0, 0);

        while (n_rand < 580) begin
            wait_idle();
            if (!filled && n_rand >= 290) begin
                // Fill the table, overflow it, and find the very last entry.
                filled = 1'b1;
                aset = SET_W'($urandom_range(0, NUM_SETS - 1));
                write_reg(CFG_ACTIVE_SET, CFG_DATA_W'(aset));
                write_reg(CFG_DISTANCE_LIMIT, '1);
                @(negedge aclk);
                queue_word(ACT_CLEAR, $urandom, $urandom, $urandom);
                for (int i = 0; i < MAX_POINTS + 4; i++) begin
                    if (i == MAX_POINTS - 1) begin
                        queue_word(ACT_ADD, int'(aset), 5, 5);
                    end else begin
                        queue_word(ACT_ADD, (i < MAX_POINTS) ? int'(aset) : $urandom,
                                   $urandom_range(1000, COORD_MAX), $urandom);
                    end
                end
                queue_word(ACT_QUERY, $urandom, 5, 5);
                repeat (3) queue_word(ACT_QUERY, $urandom, $urandom, $urandom);
                queue_word(ACT_CLEAR, $urandom, $urandom, $urandom);
            end else begin
                if (phase == 0) begin
                    aset = SET_W'(NUM_SETS - 1);
                    lim = '0;
                end else if (phase == 1) begin
                    aset = '0;
                    lim = '1;
                end else begin
                    aset = SET_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                              : $urandom_range(0, 3));
                    case ($urandom_range(0, 7))
                        0: lim = '0;
                        1: lim = '1;
                        2: lim = LIMIT_RESET;
                        3: lim = LIMIT_W'($urandom);
                        default: lim = LIMIT_W'($urandom_range(1, 3000));
                    endcase
                end
                spread = (lim > 0 && lim <= 3000) ? int'(lim) : $urandom_range(1, 2000);
                if ($urandom_range(0, 1)) begin
                    write_reg(CFG_ACTIVE_SET, CFG_DATA_W'(aset));
                    write_reg(CFG_DISTANCE_LIMIT, lim);
                end else begin
                    write_reg(CFG_DISTANCE_LIMIT, lim);
                    write_reg(CFG_ACTIVE_SET, CFG_DATA_W'(aset));
                end
                @(negedge aclk);
                if (stored > 200 || $urandom_range(0, 2) != 0) begin
                    queue_word(ACT_CLEAR, $urandom, $urandom, $urandom);
                    n_rand++;
                end
                cx = pick_center();
                cy = pick_center();
                repeat ($urandom_range(0, 30)) begin
                    if ($urandom_range(0, 9) == 0) begin
                        queue_word(ACT_ADD, $urandom, $urandom, $urandom);
                    end else begin
                        queue_word(ACT_ADD, ($urandom_range(0, 2) != 0) ? int'(aset) : $urandom,
                                   jitter_coord(cx, spread), jitter_coord(cy, spread));
                    end
                    n_rand++;
                end
                repeat ($urandom_range(2, 10)) begin
                    case ($urandom_range(0, 15))
                        0: queue_word(ACT_UNUSED, $urandom, $urandom, $urandom);
                        1: begin
                            queue_word(ACT_ADD, int'(aset), jitter_coord(cx, spread),
                                       jitter_coord(cy, spread));
                            n_rand++;
                        end
                        2: begin
                            queue_word(ACT_CLEAR, $urandom, $urandom, $urandom);
                            n_rand++;
                        end
                        3, 4: begin
                            queue_word(ACT_QUERY, $urandom, qx, qy);
                            n_rand++;
                        end
                        5: begin
                            qx = $urandom_range(0, COORD_MAX);
                            qy = $urandom_range(0, COORD_MAX);
                            queue_word(ACT_QUERY, $urandom, qx, qy);
                            n_rand++;
                        end
                        default: begin
                            qx = jitter_coord(cx, 2 * spread);
                            qy = jitter_coord(cy, 2 * spread);
                            queue_word(ACT_QUERY, $urandom, qx, qy);
                            n_rand++;
                        end
                    endcase
                end
                phase++;
            end
        end

        wait_idle();
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/nps_pkg.sv
rtl/nps_ram.sv
rtl/nearest_point_search.sv
rtl/nps_checker.sv
bench/tb_nearest_point_search.sv
